// File: sv/sobel_gradient_polar_unit_assert.svh
// Assertion macros used by the checker of the Sobel gradient polar unit.
`ifndef SOBEL_GRADIENT_POLAR_UNIT_ASSERT_SVH
`define SOBEL_GRADIENT_POLAR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SGP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgp assertion failed");

// Next-cycle implication, disabled during reset.
`define SGP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgp assertion failed");

`endif

// File: sv/sgp_pkg.sv
// Package with shared constants, types and rotation tables of the gradient unit.
`default_nettype none
package sgp_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int PixelBitsDef = 10;
  localparam int RotStepsDef  = 5;

  // Fixed widths of the channel fields.
  localparam int PixW    = 10;
  localparam int OutW    = 8;
  localparam int ThrW    = 8;
  localparam int ImgWW   = 11;
  localparam int CfgDW   = 11;
  // Signed Sobel sum width for pixels of up to ten bits.
  localparam int GradW   = 13;
  // Working width of the polar coordinates.
  localparam int CoordW  = 17;
  localparam int DirW    = 9;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_WIDTH     = 1'b1
  } reg_idx_e;

  // Sobel sums handed from the front end to the polar back end.
  typedef struct packed {
    logic signed [GradW-1:0] u;
    logic signed [GradW-1:0] v;
  } grad_t;

  // Queue handshake seen by the front end.
  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

  // Queue handshake seen by the back end.
  typedef struct packed {
    logic pop;
    logic empty;
  } qrd_t;

  // Q15 cosine of (16>>i)*pi/128.
  function automatic logic [15:0] rot_cos(input logic [2:0] i);
    logic [15:0] c;
    case (i)
      3'd0:    c = 16'd30274;
      3'd1:    c = 16'd32138;
      3'd2:    c = 16'd32610;
      3'd3:    c = 16'd32729;
      3'd4:    c = 16'd32758;
      default: c = 16'd0;
    endcase
    return c;
  endfunction

  // Q15 sine of (16>>i)*pi/128.
  function automatic logic [15:0] rot_sin(input logic [2:0] i);
    logic [15:0] s;
    case (i)
      3'd0:    s = 16'd12540;
      3'd1:    s = 16'd6393;
      3'd2:    s = 16'd3212;
      3'd3:    s = 16'd1608;
      3'd4:    s = 16'd804;
      default: s = 16'd0;
    endcase
    return s;
  endfunction

  // Direction bits flipped when a rotation leaves y negative.
  function automatic logic [DirW-1:0] rot_bits(input logic [2:0] i);
    logic [DirW-1:0] b;
    b = DirW'(9'h03F >> i);
    return b;
  endfunction

endpackage
`default_nettype wire

// File: sv/sgp_if.sv
// Valid/ready channel interfaces for pixels in and gradient results out.
`default_nettype none
interface sgp_pix_if;
  logic                     valid;
  logic                     ready;
  logic [sgp_pkg::PixW-1:0] pixel;
  logic                     frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface sgp_res_if;
  logic                     valid;
  logic                     ready;
  logic [sgp_pkg::OutW-1:0] magnitude;
  logic [sgp_pkg::OutW-1:0] direction;
  modport source (output valid, magnitude, direction, input ready);
  modport sink   (input valid, magnitude, direction, output ready);
endinterface
`default_nettype wire

// File: sv/sobel_gradient_polar_unit.sv
// Sobel gradient unit: intake accepts a pixel, then commits it before taking the next; each result
// passes the polar back end (fold, rotation steps, finish, output hold), which takes no new sum before
// the previous result has left the output hold.
// A two-entry queue lets intake run ahead while results wait on the output.
// Reset clears counters, window, queue and sequencers; threshold resets to 8 and width
// to 640. The line memories are not cleared and need no clearing pass.
`default_nettype none
module sobel_gradient_polar_unit #(
  parameter int MAX_WIDTH      = sgp_pkg::MaxWidthDef,
  parameter int PIXEL_BITS     = sgp_pkg::PixelBitsDef,
  parameter int ROTATION_STEPS = sgp_pkg::RotStepsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  sgp_pix_if.sink                         pix_i,
  sgp_res_if.source                       res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [sgp_pkg::CfgDW-1:0]  cfg_data_i
);
  logic [sgp_pkg::ThrW-1:0]  threshold_q;
  logic [sgp_pkg::ImgWW-1:0] width_q;
  sgp_pkg::qwr_t  qwr;
  sgp_pkg::qrd_t  qrd;
  sgp_pkg::grad_t grad_wr, grad_rd;
  logic           q_full, pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= sgp_pkg::ThrW'(8);
      width_q     <= sgp_pkg::ImgWW'(640);
    end else if (cfg_we_i) begin
      case (sgp_pkg::reg_idx_e'(cfg_idx_i))
        sgp_pkg::REG_THRESHOLD: threshold_q <= cfg_data_i[sgp_pkg::ThrW-1:0];
        sgp_pkg::REG_WIDTH:     width_q     <= cfg_data_i[sgp_pkg::ImgWW-1:0];
        default: ;
      endcase
    end
  end

  sgp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_i),
    .image_width_i (width_q),
    .q_full_i      (q_full),
    .qwr_o         (qwr),
    .grad_o        (grad_wr)
  );

  sgp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qwr_i   (qwr),
    .wdata_i (grad_wr),
    .full_o  (q_full),
    .pop_i   (pop),
    .qrd_o   (qrd),
    .rdata_o (grad_rd)
  );

  sgp_back #(
    .ROTATION_STEPS (ROTATION_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qrd_i       (qrd),
    .grad_i      (grad_rd),
    .pop_o       (pop),
    .threshold_i (threshold_q),
    .res_o       (res_o)
  );
endmodule
`default_nettype wire

// File: sv/sgp_front.sv
// Front end: pixel intake, line memories, 3x3 window and Sobel sums.
`default_nettype none
module sgp_front #(
  parameter int MAX_WIDTH  = sgp_pkg::MaxWidthDef,
  parameter int PIXEL_BITS = sgp_pkg::PixelBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  sgp_pix_if.sink                          pix_i,
  input  wire logic [sgp_pkg::ImgWW-1:0]   image_width_i,
  input  wire logic                        q_full_i,
  output sgp_pkg::qwr_t                    qwr_o,
  output sgp_pkg::grad_t                   grad_o
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int GW = sgp_pkg::GradW;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_CALC = 2'b10
  } fstate_e;

  fstate_e state_q, state_d;

  logic [CW-1:0]         col_q;
  logic [1:0]            row_q;
  logic [PIXEL_BITS-1:0] win_q [6];
  logic [PIXEL_BITS-1:0] br_q;
  logic [PIXEL_BITS-1:0] upper_rd_q, middle_rd_q;
  logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];

  logic          accept, has_result, commit, wrap;
  logic [CW-1:0] col_start;
  logic [WW-1:0] width_eff, col_next;
  logic signed [GW-1:0] tl, ml, bl, tm, bm, tr, mr, br;

  // Clamp the programmed width to the supported range.
  always_comb begin
    if (int'(image_width_i) < 3) begin
      width_eff = WW'(3);
    end else if (int'(image_width_i) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(image_width_i);
    end
  end

  assign pix_i.ready = (state_q == F_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;
  assign col_start   = pix_i.frame_start ? '0 : col_q;

  // A window is complete once two rows and two columns have been seen.
  assign has_result = (row_q >= 2'd2) && (col_q >= CW'(2));
  assign commit     = (state_q == F_CALC) && !(has_result && q_full_i);
  assign col_next   = WW'(col_q) + WW'(1);
  assign wrap       = (col_next >= width_eff);

  // Sign-safe operands for the Sobel sums.
  assign tl = signed'(GW'(win_q[0]));
  assign ml = signed'(GW'(win_q[1]));
  assign bl = signed'(GW'(win_q[2]));
  assign tm = signed'(GW'(win_q[3]));
  assign bm = signed'(GW'(win_q[5]));
  assign tr = signed'(GW'(upper_rd_q));
  assign mr = signed'(GW'(middle_rd_q));
  assign br = signed'(GW'(br_q));

  assign grad_o.u   = (tr + (mr <<< 1) + br) - (tl + (ml <<< 1) + bl);
  assign grad_o.v   = (bl + (bm <<< 1) + br) - (tl + (tm <<< 1) + tr);
  assign qwr_o.push = commit && has_result;
  assign qwr_o.full = q_full_i;

  // Two-state sequencer: accept, then compute once the memory data is back.
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (accept) state_d = F_CALC;
      F_CALC:  if (commit) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Counters and window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      for (int k = 0; k < 6; k++) win_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (accept && pix_i.frame_start) begin
        col_q <= '0;
        row_q <= '0;
      end else if (commit) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= upper_rd_q;
        win_q[4] <= middle_rd_q;
        win_q[5] <= br_q;
        if (wrap) begin
          col_q <= '0;
          if (row_q < 2'd2) row_q <= row_q + 2'd1;
        end else begin
          col_q <= col_next[CW-1:0];
        end
      end
    end
  end

  // Incoming pixel holding register.
  always_ff @(posedge clk_i) begin
    if (accept) br_q <= pix_i.pixel[PIXEL_BITS-1:0];
  end

  // Line memories: read on intake, written back on commit.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      upper_rd_q  <= upper_mem[col_start];
      middle_rd_q <= middle_mem[col_start];
    end
    if (commit) begin
      upper_mem[col_q]  <= middle_rd_q;
      middle_mem[col_q] <= br_q;
    end
  end
endmodule
`default_nettype wire

// File: sv/sgp_queue.sv
// Two-entry queue carrying Sobel sums from the front end to the back end.
`default_nettype none
module sgp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sgp_pkg::qwr_t  qwr_i,
  input  wire sgp_pkg::grad_t wdata_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output sgp_pkg::qrd_t       qrd_o,
  output sgp_pkg::grad_t      rdata_o
);
  sgp_pkg::grad_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o      = (count_q == 2'd2);
  assign qrd_o.empty = (count_q == 2'd0);
  assign qrd_o.pop   = pop_i;
  assign do_push     = qwr_i.push && !qwr_i.full;
  assign do_pop      = pop_i && !qrd_o.empty;
  assign rdata_o     = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end
endmodule
`default_nettype wire

// File: sv/sgp_back.sv
// Back end: folding, five Q15 rotations and magnitude/direction output.
`default_nettype none
module sgp_back #(
  parameter int ROTATION_STEPS = sgp_pkg::RotStepsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sgp_pkg::qrd_t             qrd_i,
  input  wire sgp_pkg::grad_t            grad_i,
  output logic                           pop_o,
  input  wire logic [sgp_pkg::ThrW-1:0]  threshold_i,
  sgp_res_if.source                      res_o
);
  localparam int XW = sgp_pkg::CoordW;
  localparam int DW = sgp_pkg::DirW;
  localparam int GW = sgp_pkg::GradW;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_ROT  = 4'b0010,
    B_FIN  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_e;

  bstate_e state_q, state_d;

  logic [2:0]           step_q;
  logic [XW-1:0]        x_q, y_q;
  logic [DW-1:0]        d_q;
  logic [sgp_pkg::OutW-1:0] mag_q, dir_q;

  // Fold signals.
  logic [GW-1:0]  au, av;
  logic [XW-1:0]  fx, fy, fx_s, fy_s;
  logic [DW-1:0]  fd;
  // Rotation signals.
  logic [15:0]    c, s;
  logic [32:0]    pxc, pys, pyc, pxs;
  logic [17:0]    qxc, qys, qyc, qxs;
  logic [18:0]    nx;
  logic signed [18:0] ny;
  logic [18:0]    ny_abs;
  // Final signals.
  logic [23:0]    y82;
  logic [10:0]    mag_w;
  logic [sgp_pkg::OutW-1:0] mag_sat;
  logic [DW:0]    d_inc;

  assign pop_o = (state_q == B_IDLE) && !qrd_i.empty;

  // Half-plane, quadrant and octant folds of the scaled Sobel sums.
  always_comb begin
    fd = DW'(9'h03F);
    au = grad_i.u[GW-1] ? GW'(-grad_i.u) : GW'(grad_i.u);
    av = grad_i.v[GW-1] ? GW'(-grad_i.v) : GW'(grad_i.v);
    if (grad_i.v[GW-1]) fd = fd ^ DW'(9'h1FF);
    if (grad_i.u[GW-1]) fd = fd ^ DW'(9'h0FF);
    fx = XW'(au) << 3;
    fy = XW'(av) << 3;
    fx_s = fx;
    fy_s = fy;
    if (fx < fy) begin
      fx_s = fy;
      fy_s = fx;
      fd   = fd ^ DW'(9'h07F);
    end
  end

  // One rotation step with rounding of each product.
  always_comb begin
    c      = sgp_pkg::rot_cos(step_q);
    s      = sgp_pkg::rot_sin(step_q);
    pxc    = 33'(x_q) * 33'(c);
    pys    = 33'(y_q) * 33'(s);
    pyc    = 33'(y_q) * 33'(c);
    pxs    = 33'(x_q) * 33'(s);
    qxc    = 18'((pxc + 33'h4000) >> 15);
    qys    = 18'((pys + 33'h4000) >> 15);
    qyc    = 18'((pyc + 33'h4000) >> 15);
    qxs    = 18'((pxs + 33'h4000) >> 15);
    nx     = 19'(qxc) + 19'(qys);
    ny     = signed'(19'(qyc)) - signed'(19'(qxs));
    ny_abs = ny[18] ? 19'(-ny) : 19'(ny);
  end

  // Rounding bit, magnitude scaling and saturation.
  assign y82     = 24'(y_q) * 24'(82);
  assign mag_w   = 11'((18'(x_q) + 18'(64)) >> 7);
  assign mag_sat = (mag_w > 11'd255) ? 8'd255 : mag_w[7:0];

  always_comb begin
    d_inc = (DW+1)'(d_q ^ DW'(y82 < 24'(x_q))) + (DW+1)'(1);
  end

  // Sequencer over rotation steps and the output hold.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (qrd_i.pop) state_d = B_ROT;
      B_ROT:   if (32'(step_q) == ROTATION_STEPS - 1) state_d = B_FIN;
      B_FIN:   state_d = B_OUT;
      B_OUT:   if (res_o.ready) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_ROT) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Coordinate, direction and result registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        x_q <= fx_s;
        y_q <= fy_s;
        d_q <= fd;
      end
      B_ROT: begin
        x_q <= XW'(nx);
        y_q <= XW'(ny_abs);
        if (ny[18]) d_q <= d_q ^ sgp_pkg::rot_bits(step_q);
      end
      B_FIN: begin
        if (mag_sat > threshold_i) begin
          mag_q <= mag_sat;
          dir_q <= d_inc[DW-1:1];
        end else begin
          mag_q <= '0;
          dir_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid     = (state_q == B_OUT);
  assign res_o.magnitude = mag_q;
  assign res_o.direction = dir_q;
endmodule
`default_nettype wire

// File: sv/sgp_checker.sv
// Port-level checker for the Sobel gradient unit and its bind.
`default_nettype none
`include "sobel_gradient_polar_unit_assert.svh"
module sgp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       res_valid_i,
  input wire logic       res_ready_i,
  input wire logic [7:0] magnitude_i,
  input wire logic [7:0] direction_i
);
  // A stalled result keeps its payload.
  `SGP_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, $stable(magnitude_i) && $stable(direction_i))
  // A suppressed result carries no direction.
  `SGP_ASSERT_NOW(a_suppress, res_valid_i && (magnitude_i == 8'd0), direction_i == 8'd0)
  // The back end returns to idle after each result transaction.
  `SGP_ASSERT_NEXT(a_res_gap, res_valid_i && res_ready_i, !res_valid_i)
endmodule

bind sobel_gradient_polar_unit sgp_checker u_sgp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .magnitude_i (res_o.magnitude),
  .direction_i (res_o.direction)
);
`default_nettype wire
